/* hdl/aids_pkg.sv */
// shared types and constants for the array insert/delete shift unit
// no dependencies; used by aids_front, aids_back and the top level
package aids_pkg;

    localparam int WORD_W = 32;
    localparam int IDX_W  = 6;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DEL_FIRST = 3'd6,
        OP_DEL_LAST  = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EDIT,
        ST_LIST,
        ST_DONE
    } t_state;

    // one classified operation as it waits in the queue
    typedef struct packed {
        t_op                       op;
        logic                      scan;
        logic                      enable;
        logic [IDX_W-1:0]          pos;
        logic signed [WORD_W-1:0]  value;
        logic signed [WORD_W-1:0]  key;
    } t_cmd;

endpackage

/* hdl/aids_front.sv */
// input side: accepts beats, classifies the operation and queues it
// depends on aids_pkg
module aids_front #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [2:0]                          i_func,
    input  logic [aids_pkg::IDX_W-1:0]          i_position,
    input  logic signed [aids_pkg::WORD_W-1:0]  i_value,
    input  logic signed [aids_pkg::WORD_W-1:0]  i_match_key,
    output logic                                o_q_valid,
    output aids_pkg::t_cmd                      o_q_cmd,
    input  logic                                i_q_pop
);

    localparam int IdxW = aids_pkg::IDX_W;

    aids_pkg::t_cmd w_cmd;
    logic           w_pos_ok;
    logic           w_push;

    aids_pkg::t_cmd r_q [2];
    logic           r_wr, n_wr;
    logic           r_rd, n_rd;
    logic [1:0]     r_cnt, n_cnt;

    assign w_pos_ok = ({1'b0, i_position} < (IdxW + 1)'(DEPTH));

    always_comb begin
        w_cmd.op     = aids_pkg::t_op'(i_func);
        w_cmd.scan   = 1'b0;
        w_cmd.enable = 1'b1;
        w_cmd.pos    = i_position;
        w_cmd.value  = i_value;
        w_cmd.key    = i_match_key;
        unique case (w_cmd.op) inside
            aids_pkg::OP_INS_FRONT, aids_pkg::OP_DEL_FRONT: begin
                w_cmd.pos = '0;
            end
            aids_pkg::OP_INS_AT, aids_pkg::OP_DEL_AT: begin
                w_cmd.enable = w_pos_ok;
            end
            aids_pkg::OP_DEL_FIRST, aids_pkg::OP_DEL_LAST: begin
                // position and enable come from the search in the back end
                w_cmd.scan   = 1'b1;
                w_cmd.enable = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rd];

    always_comb begin
        n_wr  = r_wr ^ w_push;
        n_rd  = r_rd ^ i_q_pop;
        n_cnt = r_cnt + 2'(w_push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3) && !(i_q_pop && r_cnt == 2'd0))
        else $error("queue count out of range");

endmodule

/* hdl/aids_back.sv */
// back end: holds the entry array, searches, edits and lists it
// depends on aids_pkg; fed by aids_front
module aids_back #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  aids_pkg::t_cmd                      i_q_cmd,
    output logic                                o_q_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [aids_pkg::WORD_W-1:0]  o_entry_value,
    output logic [aids_pkg::IDX_W-1:0]          o_entry_index,
    output logic                                o_empty_res,
    output logic                                o_last
);

    localparam int WordW = aids_pkg::WORD_W;
    localparam int IdxW  = aids_pkg::IDX_W;
    localparam int IW    = $clog2(DEPTH);

    aids_pkg::t_state r_state, n_state;

    logic signed [WordW-1:0] r_ent [DEPTH];
    logic signed [WordW-1:0] n_ent [DEPTH];

    aids_pkg::t_cmd r_cmd;
    logic [IW-1:0]  r_cnt;
    logic           w_cnt_last;

    logic                    r_pend_valid;
    logic signed [WordW-1:0] r_pend_value;
    logic [IdxW-1:0]         r_pend_index;

    logic                    r_out_valid;
    logic signed [WordW-1:0] r_out_value;
    logic [IdxW-1:0]         r_out_index;
    logic                    r_out_empty;
    logic                    r_out_last;

    logic w_out_free, w_nz, w_blocked, w_match;
    logic w_pop, w_rotate, w_edit, w_take, w_emit_mid, w_emit_end;

    assign w_cnt_last = (r_cnt == IW'(DEPTH - 1));
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_nz       = (r_ent[0] != '0);
    assign w_match    = (r_ent[0] == r_cmd.key);
    // a new nonzero entry can only enter the look-ahead slot if the old one can leave
    assign w_blocked  = w_nz && r_pend_valid && !w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aids_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_cmd.scan ? aids_pkg::ST_SCAN : aids_pkg::ST_EDIT;
                end
            end
            aids_pkg::ST_SCAN: begin
                if (w_cnt_last) begin
                    n_state = aids_pkg::ST_EDIT;
                end
            end
            aids_pkg::ST_EDIT: begin
                n_state = aids_pkg::ST_LIST;
            end
            aids_pkg::ST_LIST: begin
                if (!w_blocked && w_cnt_last) begin
                    n_state = aids_pkg::ST_DONE;
                end
            end
            aids_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = aids_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = aids_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        w_pop      = 1'b0;
        w_rotate   = 1'b0;
        w_edit     = 1'b0;
        w_take     = 1'b0;
        w_emit_mid = 1'b0;
        w_emit_end = 1'b0;
        unique case (r_state)
            aids_pkg::ST_IDLE: begin
                w_pop = i_q_valid;
            end
            aids_pkg::ST_SCAN: begin
                w_rotate = 1'b1;
            end
            aids_pkg::ST_EDIT: begin
                w_edit = 1'b1;
            end
            aids_pkg::ST_LIST: begin
                w_rotate   = !w_blocked;
                w_take     = !w_blocked && w_nz;
                w_emit_mid = !w_blocked && w_nz && r_pend_valid;
            end
            aids_pkg::ST_DONE: begin
                w_emit_end = w_out_free;
            end
            default: begin
            end
        endcase
    end

    assign o_q_pop = w_pop;

    // per-entry next value: rotate for scan/list, shift pattern for the edit
    for (genvar j = 0; j < DEPTH; j++) begin : g_ent
        logic signed [WordW-1:0] w_up, w_dn, w_rot;
        logic                    w_ge, w_le, w_eq, w_top;

        if (j == 0) begin : g_lo
            assign w_up = '0;
        end else begin : g_mid
            assign w_up = r_ent[j-1];
        end

        if (j == DEPTH - 1) begin : g_hi
            assign w_dn  = '0;
            assign w_rot = r_ent[0];
            assign w_top = 1'b1;
        end else begin : g_nhi
            assign w_dn  = r_ent[j+1];
            assign w_rot = r_ent[j+1];
            assign w_top = 1'b0;
        end

        assign w_ge = (IdxW'(j) >= r_cmd.pos);
        assign w_le = (IdxW'(j) <= r_cmd.pos);
        assign w_eq = (IdxW'(j) == r_cmd.pos);

        always_comb begin
            n_ent[j] = r_ent[j];
            if (w_rotate) begin
                n_ent[j] = w_rot;
            end else if (w_edit && r_cmd.enable) begin
                unique case (r_cmd.op) inside
                    aids_pkg::OP_INS_FRONT, aids_pkg::OP_INS_AT: begin
                        if (w_eq) begin
                            n_ent[j] = r_cmd.value;
                        end else if (w_ge) begin
                            n_ent[j] = w_up;
                        end
                    end
                    aids_pkg::OP_INS_BACK: begin
                        n_ent[j] = w_top ? r_cmd.value : w_dn;
                    end
                    aids_pkg::OP_DEL_FRONT, aids_pkg::OP_DEL_AT, aids_pkg::OP_DEL_FIRST: begin
                        if (w_ge) begin
                            n_ent[j] = w_dn;
                        end
                    end
                    aids_pkg::OP_DEL_BACK: begin
                        n_ent[j] = w_up;
                    end
                    aids_pkg::OP_DEL_LAST: begin
                        if (w_le) begin
                            n_ent[j] = w_up;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ent[j] <= '0;
            end else begin
                r_ent[j] <= n_ent[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= aids_pkg::ST_IDLE;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_pop || (w_rotate && w_cnt_last)) begin
                r_cnt <= '0;
            end else if (w_rotate) begin
                r_cnt <= r_cnt + 1'b1;
            end

            if (w_take) begin
                r_pend_valid <= 1'b1;
            end else if (w_emit_end) begin
                r_pend_valid <= 1'b0;
            end

            if (w_emit_mid || w_emit_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command register; a search overwrites position and enable
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cmd <= i_q_cmd;
        end else if (r_state == aids_pkg::ST_SCAN && w_match) begin
            if (r_cmd.op == aids_pkg::OP_DEL_LAST || !r_cmd.enable) begin
                r_cmd.pos    <= IdxW'(r_cnt);
                r_cmd.enable <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pend_value <= r_ent[0];
            r_pend_index <= IdxW'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_mid) begin
            r_out_value <= r_pend_value;
            r_out_index <= r_pend_index;
            r_out_empty <= 1'b0;
            r_out_last  <= 1'b0;
        end else if (w_emit_end) begin
            r_out_value <= r_pend_valid ? r_pend_value : '0;
            r_out_index <= r_pend_valid ? r_pend_index : '0;
            r_out_empty <= !r_pend_valid;
            r_out_last  <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_entry_value = r_out_value;
    assign o_entry_index = r_out_index;
    assign o_empty_res   = r_out_empty;
    assign o_last        = r_out_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> r_out_last)
        else $error("empty beat without last");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_empty) |-> (r_out_value != '0))
        else $error("listed a zero entry");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aids_pkg::ST_SCAN) |->
            (r_cmd.op == aids_pkg::OP_DEL_FIRST || r_cmd.op == aids_pkg::OP_DEL_LAST))
        else $error("search started for a non-match operation");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aids_pkg::ST_IDLE) |-> !r_pend_valid)
        else $error("look-ahead entry left over after listing");

endmodule

/* hdl/array_insert_delete_shift_unit.sv */
// top level of the array insert/delete shift unit
// depends on aids_pkg, aids_front and aids_back
//
//   channel  dir  handshake             payload
//   in       in   i_valid / o_stall     i_func, i_position, i_value, i_match_key
//   out      out  o_valid / i_stall     o_entry_value, o_entry_index, o_empty_res, o_last
//
// shift and position ops run the edit, a listing pass over the whole array, then a final beat
// match deletes add a search pass over the whole array ahead of the edit
// both passes rotate the register array so entry 0 is the only read point
// a two-deep queue lets up to two operations wait while one is listed
// i_stall holds the listing pass; reset clears the array to zeros
module array_insert_delete_shift_unit #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [2:0]                          i_func,
    input  logic [aids_pkg::IDX_W-1:0]          i_position,
    input  logic signed [aids_pkg::WORD_W-1:0]  i_value,
    input  logic signed [aids_pkg::WORD_W-1:0]  i_match_key,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [aids_pkg::WORD_W-1:0]  o_entry_value,
    output logic [aids_pkg::IDX_W-1:0]          o_entry_index,
    output logic                                o_empty_res,
    output logic                                o_last
);

    logic           w_q_valid;
    logic           w_q_pop;
    aids_pkg::t_cmd w_q_cmd;

    aids_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_match_key (i_match_key),
        .o_q_valid   (w_q_valid),
        .o_q_cmd     (w_q_cmd),
        .i_q_pop     (w_q_pop)
    );

    aids_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_q_pop       (w_q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_entry_value (o_entry_value),
        .o_entry_index (o_entry_index),
        .o_empty_res   (o_empty_res),
        .o_last        (o_last)
    );

endmodule

/* test/aids_listing_check.sv */
// listing monitor for the array insert/delete shift unit: mirrors the word array,
// predicts each operation's listing and compares it with the output channel
// depends on aids_pkg
module aids_listing_check #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [2:0]                          i_func,
    input  logic [aids_pkg::IDX_W-1:0]          i_position,
    input  logic signed [aids_pkg::WORD_W-1:0]  i_value,
    input  logic signed [aids_pkg::WORD_W-1:0]  i_match_key,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [aids_pkg::WORD_W-1:0]  i_entry_value,
    input  logic [aids_pkg::IDX_W-1:0]          i_entry_index,
    input  logic                                i_empty_res,
    input  logic                                i_last,
    output int                                  o_mismatch_cnt,
    output int                                  o_pending_cnt
);
    import aids_pkg::*;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [IDX_W-1:0]         index;
        logic                     empty;
        logic                     last;
    } listing_beat_t;

    logic signed [WORD_W-1:0] mirror [DEPTH];
    listing_beat_t            due_beats [$];
    int                       mismatches = 0;
    int                       waiting = 0;

    assign o_mismatch_cnt = mismatches;
    assign o_pending_cnt  = waiting;

    // entries at from and above move up one, the top entry falls off
    function automatic void open_slot(int from);
        for (int j = DEPTH - 1; j > from; j--) begin
            mirror[j] = mirror[j - 1];
        end
    endfunction

    // entries above from move down one, the top entry empties
    function automatic void close_slot(int from);
        for (int j = from; j < DEPTH - 1; j++) begin
            mirror[j] = mirror[j + 1];
        end
        mirror[DEPTH - 1] = '0;
    endfunction

    function automatic void apply_edit(t_op op, logic [IDX_W-1:0] pos,
                                       logic signed [WORD_W-1:0] val,
                                       logic signed [WORD_W-1:0] key);
        int hit;
        hit = -1;
        case (op)
            OP_INS_FRONT: begin
                open_slot(0);
                mirror[0] = val;
            end
            OP_INS_BACK: begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    mirror[i] = mirror[i + 1];
                end
                mirror[DEPTH - 1] = val;
            end
            OP_INS_AT: begin
                if (int'(pos) < DEPTH) begin
                    open_slot(int'(pos));
                    mirror[pos] = val;
                end
            end
            OP_DEL_FRONT: begin
                close_slot(0);
            end
            OP_DEL_BACK: begin
                open_slot(0);
                mirror[0] = '0;
            end
            OP_DEL_AT: begin
                if (int'(pos) < DEPTH) begin
                    close_slot(int'(pos));
                end
            end
            OP_DEL_FIRST: begin
                for (int i = DEPTH - 1; i >= 0; i--) begin
                    if (mirror[i] == key) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    close_slot(hit);
                end
            end
            default: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (mirror[i] == key) begin
                        hit = i;
                    end
                end
                // the lower part slides up over the hit, entry 0 empties
                if (hit >= 0) begin
                    for (int j = hit; j > 0; j--) begin
                        mirror[j] = mirror[j - 1];
                    end
                    mirror[0] = '0;
                end
            end
        endcase
    endfunction

    function automatic void queue_listing();
        listing_beat_t b;
        int            used;
        int            k;
        used = 0;
        k = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (mirror[i] != '0) begin
                used++;
            end
        end
        if (used == 0) begin
            b.value = '0;
            b.index = '0;
            b.empty = 1'b1;
            b.last  = 1'b1;
            due_beats.push_back(b);
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                if (mirror[i] != '0) begin
                    k++;
                    b.value = mirror[i];
                    b.index = i[IDX_W-1:0];
                    b.empty = 1'b0;
                    b.last  = (k == used);
                    due_beats.push_back(b);
                end
            end
        end
    endfunction

    function automatic void check_field(string field, logic signed [WORD_W:0] want,
                                        logic signed [WORD_W:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        listing_beat_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                mirror[i] = '0;
            end
            due_beats.delete();
        end else begin
            // compare before pushing, a beat can never answer its own operation
            if (i_out_valid && !i_out_stall) begin
                if (due_beats.size() == 0) begin
                    mismatches++;
                    $display("%0t: beat expected none, got value %0d index %0d",
                             $time, i_entry_value, i_entry_index);
                end else begin
                    want = due_beats.pop_front();
                    check_field("entry_value", want.value, i_entry_value);
                    check_field("entry_index", want.index, i_entry_index);
                    check_field("empty_res", want.empty, i_empty_res);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_edit(t_op'(i_func), i_position, i_value, i_match_key);
                queue_listing();
            end
        end
        waiting = due_beats.size();
    end

endmodule

/* test/tb_array_insert_delete_shift_unit.sv */
// testbench top for the array insert/delete shift unit: drives operations and
// stalls, instantiates the block and aids_listing_check, gives the verdict
// depends on aids_pkg, array_insert_delete_shift_unit and aids_listing_check
module tb_array_insert_delete_shift_unit;
    import aids_pkg::*;

    localparam int DEPTH       = 64;
    localparam int RANDOM_OPS  = 310;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     op_valid = 1'b0;
    logic                     op_stall;
    logic [2:0]               op_func = '0;
    logic [IDX_W-1:0]         op_pos = '0;
    logic signed [WORD_W-1:0] op_value = '0;
    logic signed [WORD_W-1:0] op_key = '0;
    logic                     beat_valid;
    logic                     beat_stall = 1'b0;
    logic signed [WORD_W-1:0] beat_value;
    logic [IDX_W-1:0]         beat_index;
    logic                     beat_empty;
    logic                     beat_last;

    int                       mismatches;
    int                       pending;
    int                       cycles = 0;
    int                       ops_sent = 0;
    logic signed [WORD_W-1:0] inserted [$];

    always #5 clk = ~clk;

    array_insert_delete_shift_unit #(.DEPTH(DEPTH)) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (op_valid),
        .o_stall      (op_stall),
        .i_func       (op_func),
        .i_position   (op_pos),
        .i_value      (op_value),
        .i_match_key  (op_key),
        .o_valid      (beat_valid),
        .i_stall      (beat_stall),
        .o_entry_value(beat_value),
        .o_entry_index(beat_index),
        .o_empty_res  (beat_empty),
        .o_last       (beat_last)
    );

    aids_listing_check #(.DEPTH(DEPTH)) u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (op_valid),
        .i_in_stall    (op_stall),
        .i_func        (op_func),
        .i_position    (op_pos),
        .i_value       (op_value),
        .i_match_key   (op_key),
        .i_out_valid   (beat_valid),
        .i_out_stall   (beat_stall),
        .i_entry_value (beat_value),
        .i_entry_index (beat_index),
        .i_empty_res   (beat_empty),
        .i_last        (beat_last),
        .o_mismatch_cnt(mismatches),
        .o_pending_cnt (pending)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_array_insert_delete_shift_unit failed");
            $finish;
        end
    end

    task automatic issue_op(t_op op, logic [IDX_W-1:0] pos,
                            logic signed [WORD_W-1:0] val,
                            logic signed [WORD_W-1:0] key);
        int gap;
        // some stretches run back to back
        gap = ((ops_sent % 60) < 12) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            op_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_valid <= 1'b1;
        op_func  <= op;
        op_pos   <= pos;
        op_value <= val;
        op_key   <= key;
        do @(posedge clk); while (op_stall);
        ops_sent++;
        if ((op == OP_INS_FRONT || op == OP_INS_BACK || op == OP_INS_AT) && val != '0) begin
            inserted.push_back(val);
            if (inserted.size() > 32) begin
                void'(inserted.pop_front());
            end
        end
    endtask

    task automatic random_op(int ins_pct);
        t_op                      op;
        logic [IDX_W-1:0]         pos;
        logic signed [WORD_W-1:0] val;
        logic signed [WORD_W-1:0] key;
        int                       r;
        pos = $urandom_range(0, 63);
        r = $urandom_range(0, 99);
        if (r < 5) begin
            val = '0;
        end else if (r < 20) begin
            // a few repeated words so first and last match differ
            val = $urandom_range(1, 3);
        end else if (r < 25) begin
            val = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        end else begin
            val = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 50 && inserted.size() > 0) begin
            key = inserted[$urandom_range(0, inserted.size() - 1)];
        end else if (r < 65) begin
            key = $urandom_range(1, 3);
        end else if (r < 75) begin
            key = '0;
        end else begin
            key = $urandom;
        end
        if ($urandom_range(0, 99) < ins_pct) begin
            op = t_op'($urandom_range(OP_INS_FRONT, OP_INS_AT));
        end else begin
            op = t_op'($urandom_range(OP_DEL_FRONT, OP_DEL_LAST));
        end
        issue_op(op, pos, val, key);
    endtask

    // output side: a random hold-off before each beat, with quiet stretches
    initial begin
        int hold;
        int beats;
        beats = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            hold = ((beats % 150) < 30) ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                beat_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                beat_stall <= 1'b0;
            end
            do @(posedge clk); while (!beat_valid);
            beats++;
        end
    end

    initial begin
        int ins_pct;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty array, including zero keys that match empty entries
        issue_op(OP_DEL_FRONT, '0, '0, '0);
        issue_op(OP_DEL_LAST, '0, '0, '0);
        issue_op(OP_DEL_FIRST, '0, '0, '0);
        // extreme words and positions, inserting zero
        issue_op(OP_INS_FRONT, '0, 32'sh7fffffff, '0);
        issue_op(OP_INS_BACK, '0, 32'sh80000000, '0);
        issue_op(OP_INS_AT, 6'd0, -1, '0);
        issue_op(OP_INS_AT, 6'd63, 1, '0);
        issue_op(OP_INS_AT, 6'd31, '0, '0);
        issue_op(OP_INS_AT, 6'd21, 32'sh55555555, '0);
        issue_op(OP_INS_AT, 6'd42, 32'shaaaaaaaa, '0);
        // duplicates for first and last match
        issue_op(OP_INS_FRONT, '0, 5, '0);
        issue_op(OP_INS_AT, 6'd10, 5, '0);
        issue_op(OP_INS_BACK, '0, 5, '0);
        issue_op(OP_DEL_FIRST, '0, '0, 5);
        issue_op(OP_DEL_LAST, '0, '0, 5);
        // no match leaves the array alone, then zero keys and deletes at positions, back and front
        issue_op(OP_DEL_FIRST, '0, '0, 12345);
        issue_op(OP_DEL_LAST, '0, '0, 32'sh55555554);
        issue_op(OP_DEL_FIRST, '0, '0, '0);
        issue_op(OP_DEL_LAST, '0, '0, '0);
        issue_op(OP_DEL_AT, 6'd63, '0, '0);
        issue_op(OP_DEL_AT, 6'd42, '0, '0);
        issue_op(OP_DEL_AT, 6'd21, '0, '0);
        issue_op(OP_DEL_AT, 6'd0, '0, '0);
        issue_op(OP_DEL_BACK, '0, '0, '0);
        issue_op(OP_DEL_FRONT, '0, '0, '0);

        // fill to full, churn, drain toward empty, churn again
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n < 100) begin
                ins_pct = 90;
            end else if (n < 150) begin
                ins_pct = 50;
            end else if (n < 230) begin
                ins_pct = 5;
            end else begin
                ins_pct = 55;
            end
            random_op(ins_pct);
        end
        op_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_array_insert_delete_shift_unit passed");
        end else begin
            $display("tb_array_insert_delete_shift_unit failed");
        end
        $finish;
    end

endmodule
